// File: src/ang_pkg.sv
`timescale 1ns / 1ps
// audio noise gate package: beat structs, config register map, controller commands
// no dependencies

package ang_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int COEF_W    = 24;
  localparam int THRESH_W  = 23;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = 50;

  localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_THRESHOLD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENVELOPE_RELEASE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_ATTACK      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_RELEASE     = 3'd4;

  localparam logic [COEF_W-1:0]   RST_INPUT_GAIN       = 24'd2097152;
  localparam logic [THRESH_W-1:0] RST_GATE_THRESHOLD   = 23'd83886;
  localparam logic [COEF_W-1:0]   RST_ENVELOPE_RELEASE = 24'd16770227;
  localparam logic [COEF_W-1:0]   RST_GAIN_ATTACK      = 24'd16603400;
  localparam logic [COEF_W-1:0]   RST_GAIN_RELEASE     = 24'd16770227;

  localparam logic [SAMPLE_W-1:0] UNITY_Q23 = 24'd8388608;

  typedef struct packed {
    logic                       channel;
    logic signed [SAMPLE_W-1:0] sample_in;
  } in_beat_t;

  typedef struct packed {
    logic                       channel_out;
    logic signed [SAMPLE_W-1:0] sample_out;
  } out_beat_t;

  typedef struct packed {
    logic [COEF_W-1:0]   input_gain;
    logic [THRESH_W-1:0] gate_threshold;
    logic [COEF_W-1:0]   envelope_release;
    logic [COEF_W-1:0]   gain_attack;
    logic [COEF_W-1:0]   gain_release;
  } cfg_t;

  typedef enum logic [1:0] {
    MUL_GAIN  = 2'd0,
    MUL_DECAY = 2'd1,
    MUL_STEP  = 2'd2,
    MUL_OUT   = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     load_x;
    logic     load_env;
    logic     load_tgt;
    logic     update;
    logic     load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic has_state;
  } ctrl_stat_t;

endpackage

// File: src/audio_noise_gate_unit.sv
`timescale 1ns / 1ps
// Noise gate with per-channel peak envelope and smoothed gate gain.
//
// Channels: in_valid/in_ready carry one sample beat (channel, sample_in);
// out_valid/out_ready carry one result beat (channel_out, sample_out);
// cfg_valid/cfg_ready write register cfg_index with cfg_data, always ready.
// Configuration must be written only with no sample in flight; not enforced.
// Every input beat gives exactly one output beat, in order.
// The sequencer steps are gain, decay, envelope, target, step, update,
// output product and done; a channel number at or above CHANNELS (gain
// only) goes from decay to done. The single shared 25x25 multiplier is
// used four times per sample with state, twice for a gain-only one.
// in_ready is high only while no sample is being worked on. A result waits
// in the output register; a new sample is taken while it waits, and the
// sequencer holds its final step until the output register is free.
// Reset (rst, synchronous) loads the register defaults, clears every
// envelope to zero and sets every gate gain to unity; no clearing pass.
// depends on ang_pkg, ang_cfg, ang_ctrl, ang_dp

module audio_noise_gate_unit import ang_pkg::*; #(
  parameter int CHANNELS = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_beat_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_beat_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  ang_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ang_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ang_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// File: src/ang_cfg.sv
`timescale 1ns / 1ps
// configuration register file for the noise gate
// depends on ang_pkg

module ang_cfg import ang_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data,
  output cfg_t                 cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.input_gain       <= RST_INPUT_GAIN;
      cfg.gate_threshold   <= RST_GATE_THRESHOLD;
      cfg.envelope_release <= RST_ENVELOPE_RELEASE;
      cfg.gain_attack      <= RST_GAIN_ATTACK;
      cfg.gain_release     <= RST_GAIN_RELEASE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INPUT_GAIN:       cfg.input_gain       <= cfg_data;
        REG_GATE_THRESHOLD:   cfg.gate_threshold   <= cfg_data[THRESH_W-1:0];
        REG_ENVELOPE_RELEASE: cfg.envelope_release <= cfg_data;
        REG_GAIN_ATTACK:      cfg.gain_attack      <= cfg_data;
        REG_GAIN_RELEASE:     cfg.gain_release     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: src/ang_ctrl.sv
`timescale 1ns / 1ps
// sequencing state machine for the noise gate, drives datapath commands
// depends on ang_pkg

module ang_ctrl import ang_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_GAIN  = 9'b000000010,
    S_DECAY = 9'b000000100,
    S_ENV   = 9'b000001000,
    S_TGT   = 9'b000010000,
    S_STEP  = 9'b000100000,
    S_UPD   = 9'b001000000,
    S_OMUL  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_sel = MUL_GAIN;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_GAIN;
        end
      end
      S_GAIN: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GAIN;
        state_next  = S_DECAY;
      end
      S_DECAY: begin
        cmd.load_x  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DECAY;
        state_next  = stat.has_state ? S_ENV : S_DONE;
      end
      S_ENV: begin
        cmd.load_env = 1'b1;
        state_next   = S_TGT;
      end
      S_TGT: begin
        cmd.load_tgt = 1'b1;
        state_next   = S_STEP;
      end
      S_STEP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_STEP;
        state_next  = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_OMUL;
      end
      S_OMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_OUT;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: src/ang_dp.sv
`timescale 1ns / 1ps
// noise gate datapath: shared multiplier, per-channel envelope and gain state
// depends on ang_pkg

module ang_dp import ang_pkg::*; #(
  parameter int CHANNELS = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  ctrl_cmd_t cmd,
  output ctrl_stat_t stat,
  input  in_beat_t  in_data,
  output out_beat_t out_data
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic signed [PROD_W-1:0] HALF21 = PROD_W'(64'd1 << 20);
  localparam logic signed [PROD_W-1:0] HALF23 = PROD_W'(64'd1 << 22);
  localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(64'd8388607);
  localparam logic signed [PROD_W-1:0] SAT_MIN = -PROD_W'(64'd8388608);

  logic [SAMPLE_W-1:0] env_mem  [CHANNELS];
  logic [SAMPLE_W-1:0] gain_mem [CHANNELS];

  logic                       ch;
  logic signed [SAMPLE_W-1:0] samp;
  logic signed [PROD_W-1:0]   p;
  logic signed [SAMPLE_W-1:0] x;
  logic [SAMPLE_W-1:0]        env_new;
  logic                       open;
  logic                       rising;
  logic                       falling;
  logic [SAMPLE_W-1:0]        diff;
  logic [SAMPLE_W-1:0]        g_new;

  logic [CH_W-1:0]            idx;
  logic [SAMPLE_W-1:0]        env_rd;
  logic [SAMPLE_W-1:0]        gain_rd;
  logic signed [SAMPLE_W:0]   op_a;
  logic signed [SAMPLE_W:0]   op_b;
  logic signed [PROD_W-1:0]   rnd21;
  logic signed [PROD_W-1:0]   rnd23;
  logic signed [SAMPLE_W-1:0] x_sat;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic [SAMPLE_W-1:0]        mag;
  logic [SAMPLE_W-1:0]        dec;
  logic [SAMPLE_W-1:0]        step;
  logic [SAMPLE_W-1:0]        target;

  assign idx            = CH_W'(ch);
  assign stat.has_state = (32'(ch) < CHANNELS);
  assign env_rd         = stat.has_state ? env_mem[idx]  : '0;
  assign gain_rd        = stat.has_state ? gain_mem[idx] : '0;

  always_comb begin
    case (cmd.mul_sel)
      MUL_GAIN: begin
        op_a = {samp[SAMPLE_W-1], samp};
        op_b = {1'b0, cfg.input_gain};
      end
      MUL_DECAY: begin
        op_a = {1'b0, env_rd};
        op_b = {1'b0, cfg.envelope_release};
      end
      MUL_STEP: begin
        op_a = {1'b0, diff};
        op_b = {1'b0, rising ? cfg.gain_attack : cfg.gain_release};
      end
      MUL_OUT: begin
        op_a = {x[SAMPLE_W-1], x};
        op_b = {1'b0, g_new};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // rounding and saturation of the two scaled products
  always_comb begin
    rnd21 = (p + HALF21) >>> 21;
    rnd23 = (p + HALF23) >>> 23;
    if (rnd21 > SAT_MAX) begin
      x_sat = SAT_MAX[SAMPLE_W-1:0];
    end else if (rnd21 < SAT_MIN) begin
      x_sat = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      x_sat = rnd21[SAMPLE_W-1:0];
    end
    if (rnd23 > SAT_MAX) begin
      y_sat = SAT_MAX[SAMPLE_W-1:0];
    end else if (rnd23 < SAT_MIN) begin
      y_sat = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      y_sat = rnd23[SAMPLE_W-1:0];
    end
  end

  assign mag    = x[SAMPLE_W-1] ? (~x + 1'b1) : x;
  assign dec    = p[47:24];
  assign step   = p[47:24];
  assign target = open ? UNITY_Q23 : '0;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ch   <= in_data.channel;
      samp <= in_data.sample_in;
    end
    if (cmd.mul_en) begin
      p <= PROD_W'(op_a * op_b);
    end
    if (cmd.load_x) begin
      x <= x_sat;
    end
    if (cmd.load_env) begin
      env_new <= (mag > dec) ? mag : dec;
    end
    if (cmd.load_tgt) begin
      open    <= (env_new >= {1'b0, cfg.gate_threshold});
      rising  <= (env_new >= {1'b0, cfg.gate_threshold}) && (gain_rd < UNITY_Q23);
      falling <= (env_new >= {1'b0, cfg.gate_threshold}) ? 1'b0 : (gain_rd != '0);
      diff    <= (env_new >= {1'b0, cfg.gate_threshold}) ? (UNITY_Q23 - gain_rd) : gain_rd;
    end
    if (cmd.update) begin
      g_new <= falling ? (target + step) : (target - step);
    end
    if (cmd.load_out) begin
      out_data.channel_out <= ch;
      out_data.sample_out  <= stat.has_state ? y_sat : x;
    end
  end

  // per-channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        env_mem[i]  <= '0;
        gain_mem[i] <= UNITY_Q23;
      end
    end else if (cmd.update && stat.has_state) begin
      env_mem[idx]  <= env_new;
      gain_mem[idx] <= falling ? (target + step) : (target - step);
    end
  end

endmodule

// File: tb/tb_audio_noise_gate_unit.sv
`timescale 1ns / 1ps
// testbench for audio_noise_gate_unit: directed and random sample beats checked against
// an in-bench predictor of gain, peak envelope and gate smoothing, with random stalls
// depends on ang_pkg and audio_noise_gate_unit

module tb_audio_noise_gate_unit;
  import ang_pkg::*;

  localparam int N_CH       = 2;
  localparam int DRAIN      = 16;
  localparam int LONG_HOLD  = 300;
  localparam int PHASE_BEATS = 260;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_MID = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI  = 3'd7;
  localparam logic signed [SAMPLE_W-1:0] FS_POS = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] FS_NEG = 24'sh800000;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;

  // predictor state
  cfg_t gate_cfg;
  logic [SAMPLE_W-1:0] env_level [N_CH];
  logic [SAMPLE_W-1:0] gain_level [N_CH];
  out_beat_t pending_out [$];

  int errors = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int hold_left = 0;
  int hold_req = 0;
  int hold_seen = 0;

  audio_noise_gate_unit #(.CHANNELS(N_CH)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic longint clip_sample(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic void reset_predictor();
    gate_cfg.input_gain       = RST_INPUT_GAIN;
    gate_cfg.gate_threshold   = RST_GATE_THRESHOLD;
    gate_cfg.envelope_release = RST_ENVELOPE_RELEASE;
    gate_cfg.gain_attack      = RST_GAIN_ATTACK;
    gate_cfg.gain_release     = RST_GAIN_RELEASE;
    for (int c = 0; c < N_CH; c++) begin
      env_level[c]  = '0;
      gain_level[c] = UNITY_Q23;
    end
  endfunction

  // gain, envelope, gate target, smoothed gain, output product
  function automatic out_beat_t gate_sample(in_beat_t b);
    out_beat_t r;
    longint xs;
    longint ys;
    int ch;
    logic [SAMPLE_W-1:0] mag, dec, env_n, tgt, g, coef, diff, stp;
    ch = int'(b.channel);
    xs = longint'(b.sample_in) * longint'(gate_cfg.input_gain);
    xs = clip_sample((xs + (64'sd1 <<< 20)) >>> 21);
    ys = xs;
    if (ch < N_CH) begin
      mag = (xs < 0) ? SAMPLE_W'(-xs) : SAMPLE_W'(xs);
      dec = SAMPLE_W'((longint'(env_level[ch]) * longint'(gate_cfg.envelope_release)) >> 24);
      env_n = (mag > dec) ? mag : dec;
      tgt = (env_n >= {1'b0, gate_cfg.gate_threshold}) ? UNITY_Q23 : '0;
      g = gain_level[ch];
      coef = (tgt > g) ? gate_cfg.gain_attack : gate_cfg.gain_release;
      diff = (g > tgt) ? g - tgt : tgt - g;
      stp = SAMPLE_W'((longint'(diff) * longint'(coef)) >> 24);
      g = (g > tgt) ? tgt + stp : tgt - stp;
      env_level[ch] = env_n;
      gain_level[ch] = g;
      ys = clip_sample((xs * longint'(g) + (64'sd1 <<< 22)) >>> 23);
    end
    r.channel_out = b.channel;
    r.sample_out = SAMPLE_W'(ys);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // receiver: random stalls, long hold on request, beat check
  always @(posedge clk) begin
    out_beat_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_out.size() == 0) begin
          report_mismatch("unexpected beat, sample_out", out_data.sample_out, 0);
        end else begin
          want = pending_out.pop_front();
          if (out_data.channel_out !== want.channel_out)
            report_mismatch("channel_out", out_data.channel_out, want.channel_out);
          if (out_data.sample_out !== want.sample_out)
            report_mismatch("sample_out", out_data.sample_out, want.sample_out);
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= LONG_HOLD;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  task automatic send_sample(input logic ch, input logic signed [SAMPLE_W-1:0] s);
    in_beat_t b;
    b.channel = ch;
    b.sample_in = s;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    pending_out.push_back(gate_sample(b));
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_INPUT_GAIN:       gate_cfg.input_gain = val;
      REG_GATE_THRESHOLD:   gate_cfg.gate_threshold = val[THRESH_W-1:0];
      REG_ENVELOPE_RELEASE: gate_cfg.envelope_release = val;
      REG_GAIN_ATTACK:      gate_cfg.gain_attack = val;
      REG_GAIN_RELEASE:     gate_cfg.gain_release = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [COEF_W-1:0] random_coef();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3: return COEF_W'($urandom);
      default: return 24'hFFFFFF - COEF_W'($urandom_range(0, 1 << 16));
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] random_gain();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return COEF_W'($urandom);
      default: return COEF_W'($urandom_range(1 << 20, 1 << 22));
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] random_threshold();
    case ($urandom_range(9))
      0: return '0;
      1: return 24'h7FFFFF;
      2: return COEF_W'($urandom);
      default: return COEF_W'($urandom_range(0, 1 << 18));
    endcase
  endfunction

  // loud bursts and quiet stretches, some full-range noise and full scale
  function automatic logic signed [SAMPLE_W-1:0] random_level(bit loud);
    int r;
    int amp;
    logic signed [SAMPLE_W-1:0] v;
    r = $urandom_range(99);
    if (r < 4) begin
      v = r[0] ? FS_POS : FS_NEG;
    end else if (r < 14) begin
      v = SAMPLE_W'($urandom);
    end else begin
      amp = loud ? $urandom_range(1, (1 << 23) - 1) : (1 << $urandom_range(2, 16));
      v = SAMPLE_W'($urandom_range(0, amp));
      if ($urandom_range(1)) v = -v;
    end
    return v;
  endfunction

  task automatic test_reset_defaults();
    send_sample(1'b0, '0);
    send_sample(1'b0, FS_POS);
    send_sample(1'b1, FS_NEG);
    send_sample(1'b1, 24'sd1);
    send_sample(1'b0, -24'sd1);
    send_sample(1'b1, 24'sh555555);
    send_sample(1'b0, 24'shAAAAAA);
  endtask

  task automatic test_register_extremes();
    settle_block();
    write_reg(REG_INPUT_GAIN, '1);
    send_sample(1'b0, 24'sd4000000);
    send_sample(1'b1, -24'sd4000000);
    settle_block();
    write_reg(REG_INPUT_GAIN, '0);
    send_sample(1'b0, FS_POS);
    settle_block();
    write_reg(REG_INPUT_GAIN, RST_INPUT_GAIN);
    write_reg(REG_UNMAPPED_LO, '0);
    write_reg(REG_UNMAPPED_HI, '1);
    write_reg(REG_UNMAPPED_MID, 24'h123456);
    send_sample(1'b1, 24'sd77777);
    settle_block();
    // zero threshold keeps the gate open
    write_reg(REG_GATE_THRESHOLD, '0);
    write_reg(REG_ENVELOPE_RELEASE, '0);
    write_reg(REG_GAIN_ATTACK, '1);
    write_reg(REG_GAIN_RELEASE, '0);
    send_sample(1'b0, '0);
    send_sample(1'b1, '0);
    settle_block();
    write_reg(REG_GATE_THRESHOLD, '1);
    write_reg(REG_ENVELOPE_RELEASE, '1);
    write_reg(REG_GAIN_ATTACK, '0);
    write_reg(REG_GAIN_RELEASE, '1);
    send_sample(1'b0, FS_POS);
    send_sample(1'b0, FS_NEG);
    send_sample(1'b1, 24'sd100);
    send_sample(1'b1, -24'sd100);
    settle_block();
    write_reg(REG_GAIN_RELEASE, '0);
    send_sample(1'b0, 24'sd1000);
    send_sample(1'b0, -24'sd1000);
  endtask

  task automatic run_random_phase(input int snd_idle, input int rcv_idle);
    bit loud;
    int run_left;
    in_idle_pct = snd_idle;
    out_idle_pct = rcv_idle;
    for (int k = 0; k < 2; k++) begin
      settle_block();
      write_reg(REG_INPUT_GAIN, random_gain());
      write_reg(REG_GATE_THRESHOLD, random_threshold());
      write_reg(REG_ENVELOPE_RELEASE, random_coef());
      write_reg(REG_GAIN_ATTACK, random_coef());
      write_reg(REG_GAIN_RELEASE, random_coef());
      if ($urandom_range(1))
        write_reg(CFG_IDX_W'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)), COEF_W'($urandom));
      loud = 1'b1;
      run_left = 0;
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (run_left == 0) begin
          loud = ~loud;
          run_left = $urandom_range(10, 60);
        end
        run_left--;
        send_sample(1'(($urandom_range(1))), random_level(loud));
      end
    end
  endtask

  task automatic test_output_backpressure();
    settle_block();
    in_idle_pct = 0;
    out_idle_pct = 0;
    hold_req++;
    for (int i = 0; i < 40; i++)
      send_sample(1'(i % 2), random_level(1'b1));
  endtask

  initial begin
    reset_predictor();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    in_idle_pct = 13;
    out_idle_pct = 46;
    test_reset_defaults();
    test_register_extremes();
    run_random_phase(13, 46);
    run_random_phase(46, 13);
    run_random_phase(0, 0);
    test_output_backpressure();
    settle_block();
    if (errors == 0 && pending_out.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
